// ----- hw/rtl/five_ary_min_heap_unit_defines.svh -----
// ============================================================================
// Five-ary min-heap unit assertion macros
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ============================================================================
`ifndef FIVE_ARY_MIN_HEAP_UNIT_DEFINES_SVH
`define FIVE_ARY_MIN_HEAP_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define FMH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("five_ary_min_heap_unit: check failed");

// Check cons in the cycle after ante.
`define FMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("five_ary_min_heap_unit: check failed");

`endif

// ----- hw/rtl/fmh_pkg.sv -----
// ============================================================================
// Five-ary min-heap package
// Sizes, codes, sequencer states, memory request type and index helpers.
// ============================================================================
package fmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int ARITY    = 5;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FC_W     = ADDR_W + $clog2(ARITY) + 1;
    localparam int SCAN_W   = $clog2(ARITY);

    // Parent index by reciprocal multiply, exact over the address range.
    localparam int PAR_SHIFT = ADDR_W + 4;
    localparam int PAR_RECIP = ((2 ** PAR_SHIFT) + ARITY - 1) / ARITY;
    localparam int PROD_W    = ADDR_W + PAR_SHIFT;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_WAIT,
        S_DEL_LAST,
        S_DEL_ROOT,
        S_DN_CHECK,
        S_DN_SCAN,
        S_DN_DECIDE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        key_t  wdata;
        addr_t raddr;
    } ram_req_t;

    // Zero-based parent address: (a - 1) / ARITY, for a > 0.
    function automatic addr_t parent_addr(input addr_t a);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(a - 1'b1) * PROD_W'(PAR_RECIP);
        return prod[PAR_SHIFT +: ADDR_W];
    endfunction

    // Zero-based first child address: ARITY * a + 1.
    function automatic logic [FC_W-1:0] first_child(input addr_t a);
        return FC_W'(a) * FC_W'(ARITY) + FC_W'(1);
    endfunction

endpackage

// ----- hw/rtl/five_ary_min_heap_unit.sv -----
// ============================================================================
// Five-ary min-heap unit
// Priority queue of signed keys: insert with sift-up, delete-min with
// sift-down, driven by a sequencer around one key store and one comparator.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   request | req_valid, req_stall | opcode, key
//   result  | rsp_valid, rsp_stall | min_key, status, entries
//
// Insert moves the new key up, comparing it with one parent per level, and
// writes it where it stops. Delete reads the last key and the root, then per
// level reads the children one at a time through the single read port, picks
// the smallest and compares it with the moving key. Full or empty rejects go
// straight to the result. Reset clears the state, the count and rsp_valid only.
// The next request is taken while a result waits under rsp_stall.
// ============================================================================
`include "five_ary_min_heap_unit_defines.svh"

module five_ary_min_heap_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      opcode,
    input  fmh_pkg::key_t             key,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output fmh_pkg::key_t             min_key,
    output logic [1:0]                status,
    output logic [fmh_pkg::CNT_W-1:0] entries
);
    import fmh_pkg::*;

    state_t            state_reg, state_next;
    cnt_t              count_reg, count_next;
    logic              rsp_valid_reg, rsp_valid_next;
    addr_t             pos_reg, pos_next;
    key_t              val_reg, val_next;
    key_t              best_reg, best_next;
    addr_t             best_addr_reg, best_addr_next;
    addr_t             caddr_reg, caddr_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    key_t              min_res_reg, min_res_next;
    logic [1:0]        status_res_reg, status_res_next;
    key_t              min_key_reg, min_key_next;
    logic [1:0]        status_reg, status_next;
    cnt_t              entries_reg, entries_next;

    ram_req_t          ram_req;
    key_t              rdata;
    key_t              cmp_a, cmp_b;
    logic              cmp_less;

    addr_t             par;
    logic [FC_W-1:0]   first;
    cnt_t              cnt_m1;
    cnt_t              next_child;
    logic              heap_full, heap_empty, more_children, take;

    fmh_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    fmh_cmp u_cmp (
        .a    (cmp_a),
        .b    (cmp_b),
        .less (cmp_less)
    );

    assign par           = parent_addr(pos_reg);
    assign first         = first_child(pos_reg);
    assign cnt_m1        = count_reg - 1'b1;
    assign next_child    = CNT_W'(caddr_reg) + 1'b1;
    assign heap_full     = (count_reg == CNT_W'(CAPACITY));
    assign heap_empty    = (count_reg == '0);
    assign more_children = (scan_reg < SCAN_W'(ARITY - 1)) && (next_child < count_reg);
    assign take          = (scan_reg == '0) || cmp_less;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (opcode == OP_INSERT)
                    begin
                        state_next = heap_full ? S_FINISH : S_UP_CHECK;
                    end
                    else
                    begin
                        state_next = heap_empty ? S_FINISH : S_DEL_LAST;
                    end
                end
            end
            S_UP_CHECK:  state_next = (pos_reg == '0) ? S_FINISH : S_UP_WAIT;
            S_UP_WAIT:   state_next = cmp_less ? S_UP_CHECK : S_FINISH;
            S_DEL_LAST:  state_next = S_DEL_ROOT;
            S_DEL_ROOT:  state_next = (count_reg == CNT_W'(1)) ? S_FINISH : S_DN_CHECK;
            S_DN_CHECK:  state_next = (first < FC_W'(count_reg)) ? S_DN_SCAN : S_FINISH;
            S_DN_SCAN:   state_next = more_children ? S_DN_SCAN : S_DN_DECIDE;
            S_DN_DECIDE: state_next = cmp_less ? S_DN_CHECK : S_FINISH;
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        best_next       = best_reg;
        best_addr_next  = best_addr_reg;
        caddr_next      = caddr_reg;
        scan_next       = scan_reg;
        min_res_next    = min_res_reg;
        status_res_next = status_res_reg;
        min_key_next    = min_key_reg;
        status_next     = status_reg;
        entries_next    = entries_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        ram_req         = '0;
        cmp_a           = val_reg;
        cmp_b           = rdata;
        case (state_reg)
            S_IDLE:
            begin
                min_res_next    = '0;
                status_res_next = ST_OK;
                if (req_valid)
                begin
                    if (opcode == OP_INSERT)
                    begin
                        if (heap_full)
                        begin
                            status_res_next = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            pos_next   = count_reg[ADDR_W-1:0];
                            val_next   = key;
                        end
                    end
                    else
                    begin
                        if (heap_empty)
                        begin
                            status_res_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_req.raddr = cnt_m1[ADDR_W-1:0];
                        end
                    end
                end
            end
            S_UP_CHECK:
            begin
                if (pos_reg == '0)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = val_reg;
                end
                else
                begin
                    ram_req.raddr = par;
                end
            end
            S_UP_WAIT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                if (cmp_less)
                begin
                    ram_req.wdata = rdata;
                    pos_next      = par;
                end
                else
                begin
                    ram_req.wdata = val_reg;
                end
            end
            S_DEL_LAST:
            begin
                val_next      = rdata;
                ram_req.raddr = '0;
            end
            S_DEL_ROOT:
            begin
                min_res_next = rdata;
                count_next   = cnt_m1;
                pos_next     = '0;
            end
            S_DN_CHECK:
            begin
                if (first < FC_W'(count_reg))
                begin
                    ram_req.raddr = first[ADDR_W-1:0];
                    caddr_next    = first[ADDR_W-1:0];
                    scan_next     = '0;
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = val_reg;
                end
            end
            S_DN_SCAN:
            begin
                cmp_a = rdata;
                cmp_b = best_reg;
                if (take)
                begin
                    best_next      = rdata;
                    best_addr_next = caddr_reg;
                end
                if (more_children)
                begin
                    ram_req.raddr = next_child[ADDR_W-1:0];
                    caddr_next    = next_child[ADDR_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
            end
            S_DN_DECIDE:
            begin
                cmp_a         = best_reg;
                cmp_b         = val_reg;
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                if (cmp_less)
                begin
                    ram_req.wdata = best_reg;
                    pos_next      = best_addr_reg;
                end
                else
                begin
                    ram_req.wdata = val_reg;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    min_key_next   = min_res_reg;
                    status_next    = status_res_reg;
                    entries_next   = count_reg;
                end
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        best_reg       <= best_next;
        best_addr_reg  <= best_addr_next;
        caddr_reg      <= caddr_next;
        scan_reg       <= scan_next;
        min_res_reg    <= min_res_next;
        status_res_reg <= status_res_next;
        min_key_reg    <= min_key_next;
        status_reg     <= status_next;
        entries_reg    <= entries_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign min_key   = min_key_reg;
    assign status    = status_reg;
    assign entries   = entries_reg;

    `FMH_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `FMH_ASSERT_NOW(a_empty_entries, rsp_valid && status == ST_EMPTY, entries == '0)
    `FMH_ASSERT_NOW(a_full_entries, rsp_valid && status == ST_FULL, entries == CNT_W'(CAPACITY))
    `FMH_ASSERT_NEXT(a_scan_bound, state_reg == S_DN_SCAN, scan_reg < SCAN_W'(ARITY))

endmodule

// ----- hw/rtl/fmh_ram.sv -----
// ============================================================================
// Five-ary min-heap key store
// Single write port, single read port with registered read data.
// ============================================================================
module fmh_ram (
    input  logic              clk,
    input  fmh_pkg::ram_req_t req,
    output fmh_pkg::key_t     rdata
);
    import fmh_pkg::*;

    key_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ----- hw/rtl/fmh_cmp.sv -----
// ============================================================================
// Five-ary min-heap key comparator
// Shared signed less-than used by every sift step.
// ============================================================================
module fmh_cmp (
    input  fmh_pkg::key_t a,
    input  fmh_pkg::key_t b,
    output logic          less
);
    import fmh_pkg::*;

    assign less = (a < b);

endmodule

// ----- verif/tb_five_ary_min_heap_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Five-ary min-heap unit testbench
// Sends insert and delete-min requests and checks every result against a
// software heap of the same shape. The run covers empty and full rejects,
// extreme and repeated keys, and a fill to capacity with mixed traffic on top.
// Both sides idle and stall at random.
// ============================================================================
module tb_five_ary_min_heap_unit;
    import fmh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic op;
        key_t key;
    } heap_req_t;

    typedef struct {
        key_t       min_key;
        logic [1:0] status;
        cnt_t       entries;
    } heap_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic       opcode = OP_INSERT;
    key_t       key = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    key_t       min_key;
    logic [1:0] status;
    cnt_t       entries;

    heap_req_t    pending_reqs[$];
    heap_result_t expected_results[$];

    key_t heap_keys [1:CAPACITY];
    int   held = 0;
    int   gen_count = 0;
    int   peak_held = 0;
    int   full_rejects = 0;
    int   empty_rejects = 0;
    int   requests_sent = 0;
    int   results_checked = 0;
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   flow_left = 0;
    bit   no_idle = 1'b0;

    five_ary_min_heap_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .opcode    (opcode),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .min_key   (min_key),
        .status    (status),
        .entries   (entries)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic key_t rand_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return key_t'($urandom);
        if (sel < 8)
            return key_t'($urandom_range(0, 8)) - key_t'(4);
        if (sel == 8)
            return $urandom_range(0, 1) ? key_t'(32'h7fff_ffff) : key_t'(32'h8000_0000);
        if ($urandom_range(0, 1))
            return key_t'(32'h7fff_ffff - $urandom_range(0, 3));
        return key_t'(32'h8000_0000 + $urandom_range(0, 3));
    endfunction

    task automatic apply_heap_op(input logic op, input key_t k, output heap_result_t res);
        int   pos;
        int   par;
        int   first;
        int   best;
        int   i;
        key_t moving;
        bit   done;
        res.min_key = '0;
        res.status  = ST_OK;
        if (op == OP_INSERT) begin
            if (held >= CAPACITY) begin
                res.status = ST_FULL;
                full_rejects++;
            end
            else begin
                held++;
                pos  = held;
                done = 1'b0;
                while (pos > 1 && !done) begin
                    par = (pos - 2) / ARITY + 1;
                    if (k < heap_keys[par]) begin
                        heap_keys[pos] = heap_keys[par];
                        pos = par;
                    end
                    else
                        done = 1'b1;
                end
                heap_keys[pos] = k;
            end
        end
        else if (held == 0) begin
            res.status = ST_EMPTY;
            empty_rejects++;
        end
        else begin
            moving      = heap_keys[held];
            res.min_key = heap_keys[1];
            held--;
            if (held > 0) begin
                pos  = 1;
                done = 1'b0;
                while (!done) begin
                    first = ARITY * (pos - 1) + 2;
                    if (first > held)
                        done = 1'b1;
                    else begin
                        best = first;
                        for (i = 1; i < ARITY; i++)
                            if (first + i <= held && heap_keys[first + i] < heap_keys[best])
                                best = first + i;
                        if (heap_keys[best] < moving) begin
                            heap_keys[pos] = heap_keys[best];
                            pos = best;
                        end
                        else
                            done = 1'b1;
                    end
                end
                heap_keys[pos] = moving;
            end
        end
        res.entries = cnt_t'(held);
        if (held > peak_held)
            peak_held = held;
    endtask

    task automatic queue_req(input logic op, input key_t k);
        heap_req_t r;
        r.op  = op;
        r.key = k;
        pending_reqs.push_back(r);
        if (op == OP_INSERT && gen_count < CAPACITY)
            gen_count++;
        else if (op == OP_DELETE && gen_count > 0)
            gen_count--;
    endtask

    task automatic queue_random(input int count, input int insert_pct);
        int n;
        bit ins;
        for (n = 0; n < count; n++) begin
            if (gen_count == 0)
                ins = $urandom_range(0, 99) < 90;
            else
                ins = $urandom_range(0, 99) < insert_pct;
            if (ins)
                queue_req(OP_INSERT, rand_key());
            else
                queue_req(OP_DELETE, key_t'($urandom));
        end
    endtask

    task automatic drain_phase();
        @(posedge clk);
        #1;
        while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0) begin
            @(posedge clk);
            #1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        heap_req_t    next_req;
        heap_result_t exp_res;
        if (!rst_n) begin
            req_valid <= 1'b0;
            gap_left  <= 0;
        end
        else begin
            if (req_valid && !req_stall) begin
                apply_heap_op(opcode, key, exp_res);
                expected_results.push_back(exp_res);
                requests_sent++;
            end
            if (req_valid && req_stall) begin
                // hold
            end
            else if (gap_left > 0 && !no_idle) begin
                req_valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end
            else if (pending_reqs.size() != 0) begin
                next_req  = pending_reqs.pop_front();
                opcode    <= next_req.op;
                key       <= next_req.key;
                req_valid <= 1'b1;
                gap_left  <= no_idle ? 0 : pick_pause();
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        heap_result_t exp_res;
        if (!rst_n) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
            flow_left  <= 0;
        end
        else begin
            if (rsp_valid === 1'b1 && !rsp_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end
                else begin
                    exp_res = expected_results.pop_front();
                    results_checked++;
                    if (min_key !== exp_res.min_key) begin
                        $error("min_key: expected %0d, actual %0d", exp_res.min_key, min_key);
                        fail_count++;
                    end
                    if (status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, status);
                        fail_count++;
                    end
                    if (entries !== exp_res.entries) begin
                        $error("entries: expected %0d, actual %0d", exp_res.entries, entries);
                        fail_count++;
                    end
                end
            end
            if (no_idle) begin
                rsp_stall  <= 1'b0;
                stall_left <= 0;
            end
            else if (stall_left > 0) begin
                rsp_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (flow_left > 0) begin
                rsp_stall <= 1'b0;
                flow_left <= flow_left - 1;
            end
            else begin
                rsp_stall  <= 1'b0;
                stall_left <= pick_pause();
                flow_left  <= $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        queue_req(OP_DELETE, key_t'($urandom));
        queue_req(OP_INSERT, key_t'(0));
        queue_req(OP_INSERT, key_t'(-1));
        queue_req(OP_INSERT, key_t'(32'h7fff_ffff));
        queue_req(OP_INSERT, key_t'(32'h8000_0000));
        queue_req(OP_INSERT, key_t'(5));
        queue_req(OP_INSERT, key_t'(5));
        queue_req(OP_INSERT, key_t'(-3));
        queue_req(OP_INSERT, key_t'(5));
        queue_req(OP_INSERT, key_t'(32'h5555_aaaa));
        repeat (9) queue_req(OP_DELETE, key_t'($urandom));
        queue_req(OP_DELETE, key_t'(32'hffff_ffff));
        drain_phase();

        no_idle <= 1'b1;
        queue_random(100, 55);
        drain_phase();

        no_idle <= 1'b0;
        queue_random(150, 55);
        drain_phase();

        while (gen_count < CAPACITY)
            queue_req(OP_INSERT, rand_key());
        repeat (3) queue_req(OP_INSERT, rand_key());
        queue_random(60, 50);
        drain_phase();

        repeat (40) @(posedge clk);
        $display("Covered %0d requests and %0d results, heap occupancy up to %0d keys",
                 requests_sent, results_checked, peak_held);
        $display("Rejected inserts on a full heap: %0d, deletes on an empty heap: %0d",
                 full_rejects, empty_rejects);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/fmh_pkg.sv
hw/rtl/fmh_ram.sv
hw/rtl/fmh_cmp.sv
hw/rtl/five_ary_min_heap_unit.sv
verif/tb_five_ary_min_heap_unit.sv
